### rtl/core/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the UTF-8 byte encoder of the transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned UnitW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned SurrW   = 10;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned MaxBytes = 4;

  // queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // surrogate tags in the top six bits of a code unit
  localparam logic [5:0] HighTag = 6'b110110;
  localparam logic [5:0] LowTag  = 6'b110111;

  localparam logic [CpW-1:0] SurrBase  = 21'h10000;
  localparam logic [CpW-1:0] Lim1Byte  = 21'h80;
  localparam logic [CpW-1:0] Lim2Byte  = 21'h800;
  localparam logic [CpW-1:0] Lim3Byte  = 21'h10000;

  localparam logic [ByteW-1:0] Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Lead4 = 8'hF0;
  localparam logic [ByteW-1:0] Cont  = 8'h80;

  // one encoded character, bytes in send order
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [IdxW-1:0]                last_idx;
    logic                           malformed;
  } char_t;

  // queue status toward the back part
  typedef struct packed {
    logic  valid;
    char_t head;
  } q_head_t;

  function automatic char_t encode_char(logic [CpW-1:0] cp, logic mal);
    char_t c;
    c = '0;
    c.malformed = mal;
    if (cp < Lim1Byte) begin
      c.bytes[0] = {1'b0, cp[6:0]};
      c.last_idx = 2'd0;
    end else if (cp < Lim2Byte) begin
      c.bytes[0] = Lead2 | {3'b000, cp[10:6]};
      c.bytes[1] = Cont | {2'b00, cp[5:0]};
      c.last_idx = 2'd1;
    end else if (cp < Lim3Byte) begin
      c.bytes[0] = Lead3 | {4'b0000, cp[15:12]};
      c.bytes[1] = Cont | {2'b00, cp[11:6]};
      c.bytes[2] = Cont | {2'b00, cp[5:0]};
      c.last_idx = 2'd2;
    end else begin
      c.bytes[0] = Lead4 | {5'b00000, cp[20:18]};
      c.bytes[1] = Cont | {2'b00, cp[17:12]};
      c.bytes[2] = Cont | {2'b00, cp[11:6]};
      c.bytes[3] = Cont | {2'b00, cp[5:0]};
      c.last_idx = 2'd3;
    end
    return c;
  endfunction

endpackage

### rtl/core/u16u8_unit_if.sv
// ----------------------------------------------------------------------------
// u16u8_unit_if
// Input channel: one UTF-16 code unit per request.
// ----------------------------------------------------------------------------
interface u16u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        final_unit;

  modport source (output valid, output code_unit, output final_unit, input ready);
  modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface

### rtl/core/u16u8_byte_if.sv
// ----------------------------------------------------------------------------
// u16u8_byte_if
// Output channel: one UTF-8 byte per request.
// ----------------------------------------------------------------------------
interface u16u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       malformed;

  modport source (output valid, output out_byte, output last_byte, output malformed,
                  input ready);
  modport sink   (input valid, input out_byte, input last_byte, input malformed,
                  output ready);
endinterface

### rtl/core/utf16_to_utf8_transcoder.sv
// The unit that completes a character is written into the queue when accepted;
// its first byte then passes through the output register before it can be
// taken. A held high surrogate shows nothing.
// The serializer sends one output byte per cycle while the sink is ready; a
// character gives 1 to 4 bytes by its UTF-8 length, 4 in the worst case.
// Reset clears the surrogate hold, the two-entry queue and the output register.
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// UTF-16 code units in, UTF-8 bytes out, with a flag for broken surrogates.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  u16u8_unit_if.sink    unit_i,
  u16u8_byte_if.source  byte_o
);

  logic    q_full, push, pop;
  char_t   push_char;
  q_head_t q_head;

  // classification and surrogate pairing
  u16u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .unit_i      (unit_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_char_o (push_char)
  );

  // decoupling queue
  u16u8_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_char_i (push_char),
    .pop_i       (pop),
    .full_o      (q_full),
    .head_o      (q_head)
  );

  // byte serializer
  u16u8_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .pop_o  (pop),
    .byte_o (byte_o)
  );

endmodule

### rtl/core/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, tracks a held high surrogate and builds encoded chars.
// ----------------------------------------------------------------------------
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  u16u8_unit_if.sink        unit_i,
  input  logic              q_full_i,
  output logic              push_o,
  output char_t             push_char_o
);

  logic             pending_q, pending_d;
  logic [SurrW-1:0] high_q, high_d;
  logic             accept;
  logic             is_high, is_low;
  logic [CpW-1:0]   pair_cp;

  assign unit_i.ready = !q_full_i;
  assign accept       = unit_i.valid && !q_full_i;

  // classify the unit
  assign is_high = unit_i.code_unit[15:10] == HighTag;
  assign is_low  = unit_i.code_unit[15:10] == LowTag;
  assign pair_cp = SurrBase + {1'b0, high_q, unit_i.code_unit[SurrW-1:0]};

  // choose what goes to the queue
  always_comb begin
    pending_d   = pending_q;
    high_d      = high_q;
    push_o      = 1'b0;
    push_char_o = encode_char({5'b00000, unit_i.code_unit}, is_low);
    if (accept) begin
      if (pending_q) begin
        push_o      = 1'b1;
        push_char_o = encode_char(pair_cp, !is_low);
        pending_d   = 1'b0;
        high_d      = '0;
      end else if (is_high) begin
        if (unit_i.final_unit) begin
          push_o      = 1'b1;
          push_char_o = encode_char('0, 1'b1);
        end else begin
          pending_d = 1'b1;
          high_d    = unit_i.code_unit[SurrW-1:0];
        end
      end else begin
        push_o = 1'b1;
      end
    end
  end

  // surrogate hold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      high_q    <= '0;
    end else begin
      pending_q <= pending_d;
      high_q    <= high_d;
    end
  end

endmodule

### rtl/core/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Short register queue of encoded characters between front and back.
// ----------------------------------------------------------------------------
module u16u8_queue
  import u16u8_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  char_t   push_char_i,
  input  logic    pop_i,
  output logic    full_o,
  output q_head_t head_o
);

  char_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o       = cnt_q == QCntW'(QDepth);
  assign head_o.valid = cnt_q != '0;
  assign head_o.head  = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  function automatic logic [QPtrW-1:0] next_ptr(logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_char_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/core/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Sends the bytes of the head character, one per cycle while the sink takes them, via an output register.
// ----------------------------------------------------------------------------
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_head_t     head_i,
  output logic        pop_o,
  u16u8_byte_if.source byte_o
);

  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             last_q, mal_q;
  logic [IdxW-1:0]  idx_q;
  logic             load, is_last;

  assign load    = head_i.valid && (!out_valid_q || byte_o.ready);
  assign is_last = idx_q == head_i.head.last_idx;
  assign pop_o   = load && is_last;

  // byte index within the head character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= is_last ? '0 : idx_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (byte_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= head_i.head.bytes[idx_q];
      last_q     <= is_last;
      mal_q      <= head_i.head.malformed;
    end
  end

  assign byte_o.valid     = out_valid_q;
  assign byte_o.out_byte  = out_byte_q;
  assign byte_o.last_byte = last_q;
  assign byte_o.malformed = mal_q;

endmodule

### rtl/core/u16u8_checker.sv
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks on the byte stream of the transcoder.
// ----------------------------------------------------------------------------
module u16u8_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       last_byte_i,
  input logic       malformed_i
);

  // stalled request holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(last_byte_i) && $stable(malformed_i))
    else $error("stalled byte request changed");

  // bytes of one character follow without a gap and share the flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_byte_i |=>
      out_valid_i && (malformed_i == $past(malformed_i)))
    else $error("character bytes not contiguous or flag changed");

  // a closing byte is never a lead byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_byte_i |-> out_byte_i[7:6] != 2'b11)
    else $error("lead byte marked as last");

  // a non-closing byte is a lead or continuation byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_byte_i |-> out_byte_i[7])
    else $error("single-byte value inside a sequence");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (byte_o.valid),
  .out_ready_i (byte_o.ready),
  .out_byte_i  (byte_o.out_byte),
  .last_byte_i (byte_o.last_byte),
  .malformed_i (byte_o.malformed)
);
